/* src/btpl_pkg.sv */
// Shared types and constants for the binary trie prefix lookup block.
// No dependencies.
package btpl_pkg;

  localparam int unsigned NodeCount = 4096;
  localparam int unsigned IdxW      = $clog2(NodeCount);
  localparam int unsigned CntW      = IdxW + 1;
  localparam int unsigned PortW     = 8;
  localparam int unsigned AddrW     = 32;
  localparam int unsigned LvlW      = 6;
  localparam logic [LvlW-1:0] MaxLvl = LvlW'(AddrW);

  localparam logic OpInsert = 1'b0;
  localparam logic OpLookup = 1'b1;

  typedef struct packed {
    logic             operation;
    logic [AddrW-1:0] address;
    logic [LvlW-1:0]  prefix_length;
    logic [PortW-1:0] route_port;
  } req_t;

  typedef struct packed {
    logic [PortW-1:0] result_port;
    logic             matched;
    logic             table_full;
  } rsp_t;

  typedef struct packed {
    logic [IdxW-1:0]  left;
    logic [IdxW-1:0]  right;
    logic             has_port;
    logic [PortW-1:0] port;
  } node_t;

  typedef struct packed {
    logic load;
    logic shift;
  } chain_ctl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DONE
  } state_e;

endpackage

/* src/btpl_cell.sv */
// One address bit cell of the shift chain; loads in parallel, shifts toward the head.
// Depends on btpl_pkg.
module btpl_cell import btpl_pkg::*; (
  input  logic       clk_i,
  input  chain_ctl_t ctl_i,
  input  logic       load_bit_i,
  input  logic       next_bit_i,
  output logic       bit_o
);

  logic bit_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      bit_q <= load_bit_i;
    end else if (ctl_i.shift) begin
      bit_q <= next_bit_i;
    end
  end

  assign bit_o = bit_q;

endmodule

/* src/btpl_walker.sv */
// Trie walker: node memory, allocation counter, level sequencer and result register.
// Depends on btpl_pkg; the address bit comes from the cell chain.
module btpl_walker import btpl_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  req_t             in_data_i,
  input  logic [PortW-1:0] default_port_i,
  input  logic             bit_i,
  output chain_ctl_t       chain_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output rsp_t             out_data_o
);

  node_t mem [NodeCount];

  state_e           state_q, state_d;
  logic             op_q;
  logic [LvlW-1:0]  plen_q, lvl_q;
  logic [PortW-1:0] rport_q, best_q;
  logic [IdxW-1:0]  cur_q;
  node_t            entry_q, rd_q;
  logic             use_mem_q, rd_zero_q, found_q, full_q;
  logic [CntW-1:0]  nodes_used_q;
  logic             root_valid_q;
  logic             out_valid_q;
  rsp_t             out_q;

  logic            accept, finish, set_full, adv_read, alloc, out_free;
  logic            rd_en, we;
  logic [IdxW-1:0] rd_addr;
  node_t           wdata, ent;
  logic [IdxW-1:0] child;

  assign ent   = use_mem_q ? (rd_zero_q ? '0 : rd_q) : entry_q;
  assign child = bit_i ? ent.right : ent.left;
  assign in_stall_o = (state_q != S_IDLE);
  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (accept) state_d = S_WALK;
      S_WALK: if (finish) state_d = S_DONE;
      S_DONE: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    rd_en    = 1'b0;
    rd_addr  = child;
    we       = 1'b0;
    wdata    = ent;
    finish   = 1'b0;
    set_full = 1'b0;
    adv_read = 1'b0;
    alloc    = 1'b0;
    case (state_q)
      S_IDLE: begin
        rd_en   = accept;
        rd_addr = '0;
      end
      S_WALK: begin
        if (op_q == OpInsert) begin
          if (lvl_q == plen_q) begin
            we             = 1'b1;
            wdata.has_port = 1'b1;
            wdata.port     = rport_q;
            finish         = 1'b1;
          end else if (child != '0) begin
            rd_en    = 1'b1;
            adv_read = 1'b1;
          end else if (nodes_used_q >= CntW'(NodeCount)) begin
            we       = 1'b1;
            finish   = 1'b1;
            set_full = 1'b1;
          end else begin
            we    = 1'b1;
            alloc = 1'b1;
            if (bit_i) begin
              wdata.right = nodes_used_q[IdxW-1:0];
            end else begin
              wdata.left = nodes_used_q[IdxW-1:0];
            end
          end
        end else begin
          if (child != '0 && lvl_q != MaxLvl) begin
            rd_en    = 1'b1;
            adv_read = 1'b1;
          end else begin
            finish = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  assign chain_o.load  = accept;
  assign chain_o.shift = adv_read || alloc;

  always_ff @(posedge clk_i) begin
    if (we) mem[cur_q] <= wdata;
    if (rd_en) rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= in_data_i.operation;
      plen_q  <= (in_data_i.prefix_length > MaxLvl) ? MaxLvl : in_data_i.prefix_length;
      rport_q <= in_data_i.route_port;
      found_q <= 1'b0;
      full_q  <= 1'b0;
      lvl_q   <= '0;
      cur_q   <= '0;
    end else if (state_q == S_WALK) begin
      if (ent.has_port) begin
        found_q <= 1'b1;
        best_q  <= ent.port;
      end
      if (set_full) full_q <= 1'b1;
      if (adv_read) begin
        cur_q <= child;
        lvl_q <= lvl_q + 1'b1;
      end else if (alloc) begin
        cur_q <= nodes_used_q[IdxW-1:0];
        lvl_q <= lvl_q + 1'b1;
      end
    end
    if (rd_en) rd_zero_q <= (rd_addr == '0) && !root_valid_q;
    entry_q <= '0;
    if (state_q == S_DONE && out_free) begin
      if (op_q == OpInsert) begin
        out_q <= full_q ? rsp_t'{result_port: '0, matched: 1'b0, table_full: 1'b1}
                        : rsp_t'{result_port: rport_q, matched: 1'b1, table_full: 1'b0};
      end else begin
        out_q <= rsp_t'{result_port: found_q ? best_q : default_port_i,
                        matched: found_q, table_full: 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      nodes_used_q <= CntW'(1);
      root_valid_q <= 1'b0;
      use_mem_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (alloc) nodes_used_q <= nodes_used_q + 1'b1;
      if (we && cur_q == '0) root_valid_q <= 1'b1;
      if (rd_en) begin
        use_mem_q <= 1'b1;
      end else if (alloc) begin
        use_mem_q <= 1'b0;
      end
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_pool_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nodes_used_q <= CntW'(NodeCount)) else $error("node count beyond pool");
  a_write_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (CntW'(cur_q) < nodes_used_q)) else $error("write to unallocated node");
  a_lvl_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> (lvl_q <= MaxLvl)) else $error("walk past last level");
  a_alloc_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alloc |=> (nodes_used_q == $past(nodes_used_q) + 1'b1)) else $error("allocation lost");

endmodule

/* src/binary_trie_prefix_lookup.sv */
// Top level: IPv4 longest prefix match over a binary trie held in node memory.
// Depends on btpl_pkg, btpl_cell and btpl_walker.
//
//  channel | valid      | stall       | payload
//  in      | in_valid_i | in_stall_o  | in_data_i  (req_t)
//  out     | out_valid_o| out_stall_i | out_data_o (rsp_t)
//  cfg     | cfg_we_i   | none        | cfg_wdata_i (default port)
//
// One transaction at a time: the next request is accepted only after the result
// of the last one is registered; a lookup reads one node memory entry per trie level,
// while an insert reads only along existing nodes and allocates new ones without a read.
// Reset clears the root entry and the default port and sets the node count to one, the root.
// A finished result holds in the output register while out_stall_i is high.
module binary_trie_prefix_lookup import btpl_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  req_t             in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output rsp_t             out_data_o,
  input  logic             cfg_we_i,
  input  logic [PortW-1:0] cfg_wdata_i
);

  logic [PortW-1:0] default_port_q;
  chain_ctl_t       chain_ctl;
  logic [AddrW:0]   bits;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      default_port_q <= '0;
    end else if (cfg_we_i) begin
      default_port_q <= cfg_wdata_i;
    end
  end

  assign bits[AddrW] = 1'b0;

  for (genvar k = 0; k < AddrW; k++) begin : g_cell
    btpl_cell u_cell (
      .clk_i      (clk_i),
      .ctl_i      (chain_ctl),
      .load_bit_i (in_data_i.address[AddrW-1-k]),
      .next_bit_i (bits[k+1]),
      .bit_o      (bits[k])
    );
  end

  btpl_walker u_walker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_data_i      (in_data_i),
    .default_port_i (default_port_q),
    .bit_i          (bits[0]),
    .chain_o        (chain_ctl),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_data_o     (out_data_o)
  );

endmodule
